// File: src/page_table_walk_translate_defines.svh
// Assertion macros for the page table walker.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef PAGE_TABLE_WALK_TRANSLATE_DEFINES_SVH
`define PAGE_TABLE_WALK_TRANSLATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTWT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTWT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ptwt_pkg.sv
// Shared constants and codes for the page table walker.
// Used by the table memory, the address unit and the top level.
package ptwt_pkg;

  localparam int PTWT_TABLE_WORDS = 4096;

  localparam int DATA_W  = 64;
  localparam int VA_W    = 48;
  localparam int PN_W    = 52;   // entry bits 63:12, page number of a table or page
  localparam int BASE_W  = 52;
  localparam int WIDX_W  = 12;
  localparam int IDX_W   = 9;
  localparam int WORD_W  = PN_W + IDX_W;
  localparam int HUGE_BIT = 7;

  // Table level whose entry is being read
  localparam logic [1:0] LVL_L1 = 2'd0;
  localparam logic [1:0] LVL_L2 = 2'd1;
  localparam logic [1:0] LVL_L3 = 2'd2;
  localparam logic [1:0] LVL_L4 = 2'd3;

  localparam logic [1:0] PS_4K = 2'd0;
  localparam logic [1:0] PS_2M = 2'd1;
  localparam logic [1:0] PS_1G = 2'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_XLATE = 1'b1;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// File: src/ptwt_table_mem.sv
// Table memory: one write port, one read port with registered read data.
// Depends on ptwt_pkg for the word width and the control struct.
module ptwt_table_mem import ptwt_pkg::*; #(
  parameter int TABLE_WORDS = PTWT_TABLE_WORDS,
  localparam int AW = $clog2(TABLE_WORDS)
) (
  input  logic              clk,
  input  mem_ctl_t          ctl,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [TABLE_WORDS];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rdata_r;

endmodule

// File: src/ptwt_addr_unit.sv
// Shared entry address unit: table page number plus level index gives the
// memory word address and the window check. Depends on ptwt_pkg.
module ptwt_addr_unit import ptwt_pkg::*; #(
  parameter int TABLE_WORDS = PTWT_TABLE_WORDS,
  localparam int AW = $clog2(TABLE_WORDS)
) (
  input  logic [PN_W-1:0] tbl_pn,
  input  logic [VA_W-1:0] va,
  input  logic [1:0]      lvl,
  output logic [AW-1:0]   word_addr,
  output logic            out_win
);

  localparam logic [WORD_W-1:0] WIN_LIMIT = WORD_W'(TABLE_WORDS);

  logic [IDX_W-1:0]  idx;
  logic [WORD_W-1:0] word;

  always_comb begin
    case (lvl)
      LVL_L4:  idx = va[47:39];
      LVL_L3:  idx = va[38:30];
      LVL_L2:  idx = va[29:21];
      LVL_L1:  idx = va[20:12];
      default: idx = va[20:12];
    endcase
  end

  // Table base is page aligned, so base/8 + index is a plain concatenation
  assign word      = {tbl_pn, idx};
  assign word_addr = word[AW-1:0];
  assign out_win   = (word >= WIN_LIMIT);

endmodule

// File: src/page_table_walk_translate.sv
// Four-level x86-64 page table walker with a local table memory. A write
// transaction stores one 64-bit entry and gives its zero result in the cycle
// after it is accepted. A translate transaction reads one table entry per
// cycle through the single memory read port, the shared address unit forming
// each next entry address from the entry just read: its result is registered
// from the level-3 entry for a 1 GiB page, the level-2 entry for a 2 MiB page
// and the level-1 entry for a 4 KiB page. When the level-4, level-3, level-2
// or level-1 entry address falls outside the table window the walk stops
// without that read and gives a zero out-of-window result. busy is high while a
// walk is in flight; a new transaction may be started in the cycle that shows
// the previous result. out_valid is a single-cycle strobe and the receiver
// cannot stall it.
`include "page_table_walk_translate_defines.svh"

module page_table_walk_translate import ptwt_pkg::*; #(
  parameter int TABLE_WORDS = PTWT_TABLE_WORDS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_req_type,
  input  logic [WIDX_W-1:0] in_word_index,
  input  logic [DATA_W-1:0] in_word_data,
  input  logic [VA_W-1:0]   in_virtual_address,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_physical_address,
  output logic [1:0]        out_page_size,
  output logic              out_out_of_window,
  input  logic              cfg_we,
  input  logic [BASE_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(TABLE_WORDS);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic              state_r, state_nxt;
  logic [1:0]        lvl_r, lvl_nxt;
  logic [VA_W-1:0]   va_r, va_nxt;
  logic [BASE_W-13:0] base_r;
  logic              ov_r, ov_nxt;
  logic [DATA_W-1:0] pa_r, pa_nxt;
  logic [1:0]        ps_r, ps_nxt;
  logic              oow_r, oow_nxt;

  logic              accept;
  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     wr_addr;
  logic              wr_idx_ok;
  logic [DATA_W-1:0] rd_data;
  logic [PN_W-1:0]   unit_pn;
  logic [VA_W-1:0]   unit_va;
  logic [1:0]        unit_lvl;
  logic [AW-1:0]     unit_addr;
  logic              unit_oow;
  logic              huge;
  logic              leaf;
  logic [DATA_W-1:0] page_off;
  logic [1:0]        leaf_ps;
  logic [DATA_W-1:0] leaf_pa;

  assign busy   = (state_r == S_WALK);
  assign accept = start && !busy;

  assign wr_addr   = AW'(in_word_index);
  assign wr_idx_ok = (32'(in_word_index) < 32'(TABLE_WORDS));

  // Idle: first level from the root register; walking: from the entry just read
  assign unit_pn  = (state_r == S_IDLE) ? {12'b0, base_r} : rd_data[63:12];
  assign unit_va  = (state_r == S_IDLE) ? in_virtual_address : va_r;
  assign unit_lvl = (state_r == S_IDLE) ? LVL_L4 : lvl_r - 2'd1;

  ptwt_addr_unit #(.TABLE_WORDS(TABLE_WORDS)) u_addr (
    .tbl_pn    (unit_pn),
    .va        (unit_va),
    .lvl       (unit_lvl),
    .word_addr (unit_addr),
    .out_win   (unit_oow)
  );

  ptwt_table_mem #(.TABLE_WORDS(TABLE_WORDS)) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (in_word_data),
    .rd_addr (unit_addr),
    .rd_data (rd_data)
  );

  assign huge = rd_data[HUGE_BIT];
  assign leaf = ((lvl_r == LVL_L3) && huge) || ((lvl_r == LVL_L2) && huge)
                || (lvl_r == LVL_L1);

  always_comb begin
    case (lvl_r)
      LVL_L3: begin
        page_off = {34'b0, va_r[29:0]};
        leaf_ps  = PS_1G;
      end
      LVL_L2: begin
        page_off = {43'b0, va_r[20:0]};
        leaf_ps  = PS_2M;
      end
      default: begin
        page_off = {52'b0, va_r[11:0]};
        leaf_ps  = PS_4K;
      end
    endcase
  end

  assign leaf_pa = {rd_data[63:12], 12'b0} + page_off;

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    va_nxt        = va_r;
    ov_nxt        = 1'b0;
    pa_nxt        = pa_r;
    ps_nxt        = ps_r;
    oow_nxt       = oow_r;
    mem_ctl.rd_en = 1'b0;
    mem_ctl.wr_en = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_WRITE) begin
            mem_ctl.wr_en = wr_idx_ok;
            ov_nxt  = 1'b1;
            pa_nxt  = '0;
            ps_nxt  = PS_4K;
            oow_nxt = 1'b0;
          end else begin
            va_nxt  = in_virtual_address;
            lvl_nxt = LVL_L4;
            if (unit_oow) begin
              ov_nxt  = 1'b1;
              pa_nxt  = '0;
              ps_nxt  = PS_4K;
              oow_nxt = 1'b1;
            end else begin
              mem_ctl.rd_en = 1'b1;
              state_nxt     = S_WALK;
            end
          end
        end
      end
      S_WALK: begin
        if (leaf) begin
          ov_nxt    = 1'b1;
          pa_nxt    = leaf_pa;
          ps_nxt    = leaf_ps;
          oow_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else if (unit_oow) begin
          ov_nxt    = 1'b1;
          pa_nxt    = '0;
          ps_nxt    = PS_4K;
          oow_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          // descend one level
          mem_ctl.rd_en = 1'b1;
          lvl_nxt       = lvl_r - 2'd1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      base_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        base_r <= cfg_wdata[BASE_W-1:12];
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl_r <= lvl_nxt;
    va_r  <= va_nxt;
    pa_r  <= pa_nxt;
    ps_r  <= ps_nxt;
    oow_r <= oow_nxt;
  end

  assign out_valid            = ov_r;
  assign out_physical_address = pa_r;
  assign out_page_size        = ps_r;
  assign out_out_of_window    = oow_r;

  `PTWT_ASSERT_NEXT(a_write_done, clk, rst_n,
    accept && (in_req_type == REQ_WRITE),
    out_valid && (out_physical_address == '0) && !out_out_of_window,
    "write transaction gave no zero result")
  `PTWT_ASSERT_NEXT(a_no_spurious, clk, rst_n, !accept && !busy, !out_valid,
    "result strobe without a transaction")
  `PTWT_ASSERT_NOW(a_busy_quiet, clk, rst_n, busy, !out_valid,
    "result strobe while a walk is in flight")
  `PTWT_ASSERT_NOW(a_oow_zero, clk, rst_n, out_valid && out_out_of_window,
    (out_physical_address == '0) && (out_page_size == PS_4K),
    "window fault with nonzero address")
  `PTWT_ASSERT_NOW(a_size_code, clk, rst_n, out_valid,
    (out_page_size == PS_4K) || (out_page_size == PS_2M) || (out_page_size == PS_1G),
    "bad page size code")

endmodule
